// ----- hdl/assert_macros.svh -----
// Assertion helper macros used by polar_pattern_to_ludwig3.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error(msg);

`endif

// ----- hdl/pp2l3_pkg.sv -----
// ----------------------------------------------------------------------------
// pp2l3_pkg
// Shared constants, types and helpers for the Ludwig-3 pattern converter.
// ----------------------------------------------------------------------------
package pp2l3_pkg;

   localparam int CordicSteps = 30;
   localparam int AmpW = 32;
   localparam int CsrIdxW = 2;
   localparam int CsrDataW = 1;

   localparam logic [CsrIdxW-1:0] CSR_DB_MODE = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_SKIP_HORIZON = 2'd1;
   localparam logic [CsrIdxW-1:0] CSR_SKIP_POLES = 2'd2;

   localparam logic signed [33:0] CordicGain = 34'sd652032874;
   localparam logic signed [33:0] OneQ30 = 34'sd1073741824;
   localparam logic signed [63:0] DbToLog2 = 64'sd1426757253;
   localparam logic [63:0] Ln2Q32 = 64'd2977044472;

   // signed element types, so that selects out of packed arrays stay signed
   typedef logic signed [AmpW-1:0] amp_type;
   typedef logic signed [63:0]     wide_type;
   typedef logic signed [33:0]     trig_type;
   typedef logic signed [15:0]     expo_type;

   // 34-bit x, y, z payloads plus quadrant and bypass: one CORDIC element per sincos unit
   typedef struct packed {
      logic signed [33:0] x;
      logic signed [33:0] y;
      logic signed [33:0] z;
      logic [1:0]         quad;
      logic               bypass;
   } cordic_type;

   function automatic logic signed [33:0] atan_lut(input logic [4:0] i);
      logic signed [33:0] v;
      case (i)
         5'd0: v = 34'sd536870912;   5'd1: v = 34'sd316933406;
         5'd2: v = 34'sd167458907;   5'd3: v = 34'sd85004756;
         5'd4: v = 34'sd42667331;    5'd5: v = 34'sd21354465;
         5'd6: v = 34'sd10679838;    5'd7: v = 34'sd5340245;
         5'd8: v = 34'sd2670163;     5'd9: v = 34'sd1335087;
         5'd10: v = 34'sd667544;     5'd11: v = 34'sd333772;
         5'd12: v = 34'sd166886;     5'd13: v = 34'sd83443;
         5'd14: v = 34'sd41722;      5'd15: v = 34'sd20861;
         5'd16: v = 34'sd10430;      5'd17: v = 34'sd5215;
         5'd18: v = 34'sd2608;       5'd19: v = 34'sd1304;
         5'd20: v = 34'sd652;        5'd21: v = 34'sd326;
         5'd22: v = 34'sd163;        5'd23: v = 34'sd81;
         5'd24: v = 34'sd41;         5'd25: v = 34'sd20;
         5'd26: v = 34'sd10;         5'd27: v = 34'sd5;
         5'd28: v = 34'sd3;          5'd29: v = 34'sd1;
         default: v = 34'sd0;
      endcase
      return v;
   endfunction

   // Reciprocal of k in unsigned Q2.34, k = 1..12, for exact floor division of Horner terms.
   function automatic logic [35:0] recip_lut(input logic [3:0] k);
      logic [35:0] v;
      case (k)
         4'd1: v = 36'd17179869184;  4'd2: v = 36'd8589934592;
         4'd3: v = 36'd5726623062;   4'd4: v = 36'd4294967296;
         4'd5: v = 36'd3435973837;   4'd6: v = 36'd2863311531;
         4'd7: v = 36'd2454267027;   4'd8: v = 36'd2147483648;
         4'd9: v = 36'd1908874354;   4'd10: v = 36'd1717986919;
         4'd11: v = 36'd1561806290;  4'd12: v = 36'd1431655766;
         default: v = 36'd0;
      endcase
      return v;
   endfunction

   function automatic logic signed [AmpW-1:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[AmpW-1:0];
   endfunction

endpackage

// ----- hdl/pp2l3_if.sv -----
// ----------------------------------------------------------------------------
// pp2l3_req_if / pp2l3_rsp_if
// Valid/ready channels carrying pattern samples and Ludwig-3 results.
// ----------------------------------------------------------------------------
interface pp2l3_req_if;
   logic               valid;
   logic               ready;
   logic [15:0]        polar_angle;
   logic [15:0]        azimuth;
   logic signed [31:0] amp_theta;
   logic [15:0]        theta_phase;
   logic signed [31:0] amp_phi;
   logic [15:0]        phi_phase;
   modport source (output valid, polar_angle, azimuth, amp_theta, theta_phase,
                   amp_phi, phi_phase, input ready);
   modport sink (input valid, polar_angle, azimuth, amp_theta, theta_phase,
                 amp_phi, phi_phase, output ready);
endinterface

interface pp2l3_rsp_if;
   logic               valid;
   logic               ready;
   logic               kept;
   logic signed [31:0] horiz_re;
   logic signed [31:0] horiz_im;
   logic signed [31:0] vert_re;
   logic signed [31:0] vert_im;
   modport source (output valid, kept, horiz_re, horiz_im, vert_re, vert_im,
                   input ready);
   modport sink (input valid, kept, horiz_re, horiz_im, vert_re, vert_im,
                 output ready);
endinterface

// ----- hdl/polar_pattern_to_ludwig3.sv -----
// ----------------------------------------------------------------------------
// polar_pattern_to_ludwig3
// Converts polar antenna pattern samples into Ludwig-3 H/V components.
// ----------------------------------------------------------------------------
// One sample is accepted per clock while the pipe is not frozen, and one
// result beat leaves per sample, in order. The datapath is a single
// stall-together pipeline: dB-to-linear (two stages of multiply plus a chain
// of twelve Horner cells, two stages each), one stage of scaling and CORDIC
// setup, a chain of 30 CORDIC cells producing three sine/cosine pairs at once,
// then three multiply and sum stages. The whole pipe freezes while the result
// register is full and not taken, so input ready is high exactly when the
// result register is empty or being read in the same cycle.
module polar_pattern_to_ludwig3 #(
   parameter int Steps = pp2l3_pkg::CordicSteps
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [pp2l3_pkg::CsrIdxW-1:0] csr_index,
   input  logic [pp2l3_pkg::CsrDataW-1:0] csr_wdata,
   pp2l3_req_if.sink                     req,
   pp2l3_rsp_if.source                   rsp
);
   import pp2l3_pkg::*;
   `include "assert_macros.svh"

   localparam int ExpCells = 12;
   localparam int PreLat = 2 + 2 * ExpCells;
   localparam int Lat = PreLat + Steps + 4;

   logic db_mode_ff, skip_hz_ff, skip_pole_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         db_mode_ff <= 1'b0;
         skip_hz_ff <= 1'b0;
         skip_pole_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_DB_MODE:      db_mode_ff <= csr_wdata[0];
            CSR_SKIP_HORIZON: skip_hz_ff <= csr_wdata[0];
            CSR_SKIP_POLES:   skip_pole_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // pipeline advance: whole pipe moves unless output is held
   logic en;
   logic [Lat-1:0] vld_ff;
   assign en = !rsp.valid || rsp.ready;
   assign req.ready = en;

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (en) vld_ff <= {vld_ff[Lat-2:0], req.valid};
   end
   assign rsp.valid = vld_ff[Lat-1];

   // ---- stage A: filters and log2 product ----
   logic drop;
   assign drop = (skip_hz_ff && req.polar_angle > 16'd16384) ||
                 (skip_pole_ff &&
                  (req.polar_angle == 16'd0 || req.polar_angle >= 16'd32768));

   logic [2:0][15:0] ang_a_ff;   // theta phase, phi phase, azimuth
   wide_type [1:0] t_ff;
   amp_type [1:0] amp_a_ff;
   logic db_a_ff, kept_a_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         ang_a_ff <= {req.azimuth, req.phi_phase, req.theta_phase};
         amp_a_ff <= {req.amp_phi, req.amp_theta};
         t_ff[0] <= 64'(req.amp_theta) * DbToLog2;
         t_ff[1] <= 64'(req.amp_phi) * DbToLog2;
         db_a_ff <= db_mode_ff;
         kept_a_ff <= !drop;
      end
   end

   // ---- stage B: split exponent, u = f*ln2 ----
   logic [1:0][39:0] e_v;
   logic [1:0][31:0] u_b_ff;
   expo_type [1:0] n_b_ff;
   logic [2:0][15:0] ang_b_ff;
   amp_type [1:0] amp_b_ff;
   logic db_b_ff, kept_b_ff;

   always_comb begin
      for (int l = 0; l < 2; l++) e_v[l] = 40'(t_ff[l] >>> 24);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int l = 0; l < 2; l++) begin
            u_b_ff[l] <= 32'((64'(e_v[l][23:0]) * Ln2Q32) >> 26);
            n_b_ff[l] <= 16'($signed(e_v[l]) >>> 24);
         end
         ang_b_ff <= ang_a_ff;
         amp_b_ff <= amp_a_ff;
         db_b_ff <= db_a_ff;
         kept_b_ff <= kept_a_ff;
      end
   end

   // ---- Horner chain ----
   logic [ExpCells:0][1:0][31:0] u_ch, p_ch;
   assign u_ch[0] = u_b_ff;
   assign p_ch[0] = {2{32'h40000000}};

   for (genvar c = 0; c < ExpCells; c++) begin : g_exp
      pp2l3_exp_cell #(.K(ExpCells - c)) u_cell (
         .clock(clock), .en(en),
         .u_in(u_ch[c]), .p_in(p_ch[c]),
         .u_out(u_ch[c+1]), .p_out(p_ch[c+1])
      );
   end

   localparam int SideD = 2 * ExpCells;
   logic [SideD-1:0][2:0][15:0] ang_d_ff;
   amp_type [SideD-1:0][1:0] amp_d_ff;
   expo_type [SideD-1:0][1:0] n_d_ff;
   logic [SideD-1:0] db_d_ff, kept_d_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         ang_d_ff <= {ang_d_ff[SideD-2:0], ang_b_ff};
         amp_d_ff <= {amp_d_ff[SideD-2:0], amp_b_ff};
         n_d_ff <= {n_d_ff[SideD-2:0], n_b_ff};
         db_d_ff <= {db_d_ff[SideD-2:0], db_b_ff};
         kept_d_ff <= {kept_d_ff[SideD-2:0], kept_b_ff};
      end
   end

   // ---- scale 2^f by 2^(n-14), select linear amplitude, CORDIC entry ----
   amp_type [1:0] lin_v;
   cordic_type [2:0] cin_v;

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         logic signed [15:0] sh;
         logic [6:0] sa;
         logic [63:0] pr;
         sh = n_d_ff[SideD-1][l] - 16'sd14;
         sa = 7'(-sh);
         pr = 64'(p_ch[ExpCells][l]);
         if (sh >= 16'sd1) lin_v[l] = 32'sh7FFFFFFF;
         else if (sh == 16'sd0) lin_v[l] = sat32(signed'(pr));
         else if (sh < -16'sd40) lin_v[l] = '0;
         else lin_v[l] = 32'((pr + (64'd1 << (sa - 7'd1))) >> sa);
         if (!db_d_ff[SideD-1]) lin_v[l] = amp_d_ff[SideD-1][l];
      end
      for (int l = 0; l < 3; l++) begin
         logic [15:0] a;
         logic signed [14:0] r;
         a = ang_d_ff[SideD-1][l] + 16'h2000;
         r = signed'(15'({1'b0, a[13:0]})) - 15'sd8192;
         cin_v[l].quad = a[15:14];
         cin_v[l].bypass = (r == 15'sd0);
         cin_v[l].x = (r == 15'sd0) ? OneQ30 : CordicGain;
         cin_v[l].y = '0;
         cin_v[l].z = 34'(r) <<< 16;
      end
   end

   amp_type [1:0] amp_c_ff;
   cordic_type [2:0] cin_ff;
   logic kept_c_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         amp_c_ff <= lin_v;
         cin_ff <= cin_v;
         kept_c_ff <= kept_d_ff[SideD-1];
      end
   end

   // ---- CORDIC chain ----
   cordic_type [Steps:0][2:0] cc;
   assign cc[0] = cin_ff;
   for (genvar s = 0; s < Steps; s++) begin : g_cordic
      pp2l3_cordic_cell #(.Step(s)) u_cell (
         .clock(clock), .en(en), .d_in(cc[s]), .d_out(cc[s+1])
      );
   end

   amp_type [Steps-1:0][1:0] amp_s_ff;
   logic [Steps-1:0] kept_s_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         amp_s_ff <= {amp_s_ff[Steps-2:0], amp_c_ff};
         kept_s_ff <= {kept_s_ff[Steps-2:0], kept_c_ff};
      end
   end

   // quadrant fold: index 0 theta phase, 1 phi phase, 2 azimuth
   trig_type [2:0] cs_v, sn_v;
   always_comb begin
      for (int l = 0; l < 3; l++) begin
         case (cc[Steps][l].quad)
            2'd0: begin cs_v[l] = cc[Steps][l].x;  sn_v[l] = cc[Steps][l].y;  end
            2'd1: begin cs_v[l] = -cc[Steps][l].y; sn_v[l] = cc[Steps][l].x;  end
            2'd2: begin cs_v[l] = -cc[Steps][l].x; sn_v[l] = -cc[Steps][l].y; end
            default: begin cs_v[l] = cc[Steps][l].y; sn_v[l] = -cc[Steps][l].x; end
         endcase
      end
   end

   // ---- component parts (|amp * trig| stays within 33 bits) ----
   logic signed [33:0] tre_ff, tim_ff, pre_ff, pim_ff;
   logic signed [33:0] cp_ff, sp_ff;
   logic kept_m_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         tre_ff <= 34'((64'(amp_s_ff[Steps-1][0]) * 64'(cs_v[0]) + 64'sd536870912) >>> 30);
         tim_ff <= 34'((64'(amp_s_ff[Steps-1][0]) * 64'(sn_v[0]) + 64'sd536870912) >>> 30);
         pre_ff <= 34'((64'(amp_s_ff[Steps-1][1]) * 64'(cs_v[1]) + 64'sd536870912) >>> 30);
         pim_ff <= 34'((64'(amp_s_ff[Steps-1][1]) * 64'(sn_v[1]) + 64'sd536870912) >>> 30);
         cp_ff <= cs_v[2];
         sp_ff <= sn_v[2];
         kept_m_ff <= kept_s_ff[Steps-1];
      end
   end

   // ---- azimuth products, then sum and round ----
   logic signed [63:0] p0_ff, p1_ff, p2_ff, p3_ff, p4_ff, p5_ff, p6_ff, p7_ff;
   logic kept_p_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         p0_ff <= 64'(tre_ff) * 64'(cp_ff);  p1_ff <= 64'(pre_ff) * 64'(sp_ff);
         p2_ff <= 64'(tim_ff) * 64'(cp_ff);  p3_ff <= 64'(pim_ff) * 64'(sp_ff);
         p4_ff <= 64'(tre_ff) * 64'(sp_ff);  p5_ff <= 64'(pre_ff) * 64'(cp_ff);
         p6_ff <= 64'(tim_ff) * 64'(sp_ff);  p7_ff <= 64'(pim_ff) * 64'(cp_ff);
         kept_p_ff <= kept_m_ff;
      end
   end

   logic kept_o_ff;
   logic signed [31:0] hre_ff, him_ff, vre_ff, vim_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         kept_o_ff <= kept_p_ff;
         hre_ff <= kept_p_ff ? sat32((p0_ff - p1_ff + 64'sd536870912) >>> 30) : '0;
         him_ff <= kept_p_ff ? sat32((p2_ff - p3_ff + 64'sd536870912) >>> 30) : '0;
         vre_ff <= kept_p_ff ? sat32((p4_ff + p5_ff + 64'sd536870912) >>> 30) : '0;
         vim_ff <= kept_p_ff ? sat32((p6_ff + p7_ff + 64'sd536870912) >>> 30) : '0;
      end
   end

   assign rsp.kept = kept_o_ff;
   assign rsp.horiz_re = hre_ff;
   assign rsp.horiz_im = him_ff;
   assign rsp.vert_re = vre_ff;
   assign rsp.vert_im = vim_ff;

   `ASSERT_IMPLY(a_dropped_zero, clock, reset, rsp.valid && !rsp.kept,
      rsp.horiz_re == 0 && rsp.vert_re == 0 && rsp.horiz_im == 0 && rsp.vert_im == 0,
      "dropped beat carries nonzero data")
   `ASSERT_NEXT(a_hold, clock, reset, rsp.valid && !rsp.ready,
      rsp.valid && $stable(rsp.horiz_re) && $stable(rsp.kept), "stalled result changed")
   `ASSERT_IMPLY(a_ready, clock, reset, !rsp.valid, req.ready,
      "input stalled while output empty")
endmodule

// ----- hdl/pp2l3_cordic_cell.sv -----
// ----------------------------------------------------------------------------
// pp2l3_cordic_cell
// One rotation-mode CORDIC micro-rotation for three sincos lanes.
// ----------------------------------------------------------------------------
module pp2l3_cordic_cell #(
   parameter int Step = 0
) (
   input  logic                       clock,
   input  logic                       en,
   input  pp2l3_pkg::cordic_type [2:0] d_in,
   output pp2l3_pkg::cordic_type [2:0] d_out
);
   import pp2l3_pkg::*;

   localparam logic signed [33:0] Atan = atan_lut(5'(Step));

   cordic_type [2:0] d_ff, d_in_nx;

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         d_in_nx[l] = d_in[l];
         if (!d_in[l].bypass) begin
            if (!d_in[l].z[33]) begin
               d_in_nx[l].x = d_in[l].x - (d_in[l].y >>> Step);
               d_in_nx[l].y = d_in[l].y + (d_in[l].x >>> Step);
               d_in_nx[l].z = d_in[l].z - Atan;
            end else begin
               d_in_nx[l].x = d_in[l].x + (d_in[l].y >>> Step);
               d_in_nx[l].y = d_in[l].y - (d_in[l].x >>> Step);
               d_in_nx[l].z = d_in[l].z + Atan;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) d_ff <= d_in_nx;
   end

   assign d_out = d_ff;
endmodule

// ----- hdl/pp2l3_exp_cell.sv -----
// ----------------------------------------------------------------------------
// pp2l3_exp_cell
// One Horner step of 2^f for both amplitudes: p = 1 + (u*p >> 30) / k.
// Two register stages: product, then reciprocal multiply and correction.
// ----------------------------------------------------------------------------
module pp2l3_exp_cell #(
   parameter int K = 12
) (
   input  logic              clock,
   input  logic              en,
   input  logic [1:0][31:0]  u_in,
   input  logic [1:0][31:0]  p_in,
   output logic [1:0][31:0]  u_out,
   output logic [1:0][31:0]  p_out
);
   import pp2l3_pkg::*;

   localparam logic [35:0] Recip = recip_lut(4'(K));

   logic [1:0][31:0] u_ff, p_ff, u2_ff;
   logic [1:0][33:0] w_ff;
   logic [1:0][31:0] p_in_nx;

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         logic [69:0] prod;
         logic [33:0] q;
         logic [35:0] rem;
         prod = 70'(w_ff[l]) * 70'(Recip);
         q = prod[67:34];
         rem = 36'(w_ff[l]) - 36'(q) * 36'(K);
         if (rem >= 36'(K)) q = q + 34'd1;
         p_in_nx[l] = 32'(64'h40000000 + 64'(q));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int l = 0; l < 2; l++) begin
            w_ff[l] <= 34'((64'(u_in[l]) * 64'(p_in[l])) >> 30);
         end
         u_ff <= u_in;
         u2_ff <= u_ff;
         p_ff <= p_in_nx;
      end
   end

   assign u_out = u2_ff;
   assign p_out = p_ff;
endmodule
